// ===== rtl/nta_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nta_pkg: shared types and constants for the note event translator
// Opcodes, write kinds, queue entry layout, timer tables and the clock
// constant shared by the front, the timer unit, the queue and the back end.
// ============================================================================
package nta_pkg;

    localparam int CLK_W                  = 26;
    localparam int TIMER_W                = 11;
    localparam int NOTE_COUNT             = 128;
    localparam int NOTE_IDX_W             = 7;
    localparam int FREQ_CENTI_W           = 21;
    localparam int FREQ_FRACTION_BITS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF        = 4;

    localparam logic [CLK_W-1:0]   STD_CLOCK = 26'd1789773;
    localparam logic [TIMER_W-1:0] TIMER_MAX = 11'd2047;

    // input opcodes
    localparam logic [2:0] OP_NOTE_ON  = 3'd0;
    localparam logic [2:0] OP_NOTE_OFF = 3'd1;
    localparam logic [2:0] OP_SET_MASK = 3'd2;
    localparam logic [2:0] OP_RAW      = 3'd3;
    localparam logic [2:0] OP_RESET    = 3'd4;

    // classified request kinds carried through the queue
    typedef logic [3:0] kind_t;
    localparam kind_t K_SQ_ON     = 4'd0;
    localparam kind_t K_TRI_ON    = 4'd1;
    localparam kind_t K_NOISE_ON  = 4'd2;
    localparam kind_t K_SQ_OFF    = 4'd3;
    localparam kind_t K_TRI_OFF   = 4'd4;
    localparam kind_t K_NOISE_OFF = 4'd5;
    localparam kind_t K_MASK      = 4'd6;
    localparam kind_t K_RAW       = 4'd7;
    localparam kind_t K_RESET     = 4'd8;

    typedef struct packed {
        kind_t               kind;
        logic                sq_sel;
        logic [3:0]          vol;
        logic [TIMER_W-1:0]  timer;
        logic [15:0]         addr;
        logic [7:0]          data;
    } entry_t;

    typedef struct packed {
        logic                  start;
        logic [NOTE_IDX_W-1:0] note_idx;
    } tmr_req_t;

    typedef struct packed {
        logic               done;
        logic [TIMER_W-1:0] timer;
    } tmr_rsp_t;

    localparam logic [7:0] ENABLE_RESET = 8'h0F;

    // timer values at the standard clock
    localparam logic [TIMER_W-1:0] TIMER_ROM [NOTE_COUNT] = '{
        11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047,
        11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047,
        11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047,
        11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047,
        11'd2047, 11'd2033, 11'd1919, 11'd1811, 11'd1709, 11'd1613, 11'd1523, 11'd1437,
        11'd1356, 11'd1280, 11'd1208, 11'd1140, 11'd1076, 11'd1016, 11'd959,  11'd905,
        11'd854,  11'd806,  11'd761,  11'd718,  11'd678,  11'd640,  11'd604,  11'd570,
        11'd538,  11'd507,  11'd479,  11'd452,  11'd427,  11'd403,  11'd380,  11'd359,
        11'd338,  11'd319,  11'd301,  11'd284,  11'd268,  11'd253,  11'd239,  11'd225,
        11'd213,  11'd201,  11'd189,  11'd179,  11'd169,  11'd159,  11'd150,  11'd142,
        11'd134,  11'd126,  11'd119,  11'd112,  11'd106,  11'd100,  11'd94,   11'd89,
        11'd84,   11'd79,   11'd75,   11'd70,   11'd66,   11'd63,   11'd59,   11'd56,
        11'd52,   11'd49,   11'd47,   11'd44,   11'd41,   11'd39,   11'd37,   11'd35,
        11'd33,   11'd31,   11'd29,   11'd27,   11'd26,   11'd24,   11'd23,   11'd21,
        11'd20,   11'd19,   11'd18,   11'd17,   11'd16,   11'd15,   11'd14,   11'd13,
        11'd12,   11'd12,   11'd11,   11'd10,   11'd10,   11'd9,    11'd8,    11'd8
    };

    // note frequencies in hundredths of a hertz
    localparam logic [FREQ_CENTI_W-1:0] FREQ_CENTI [NOTE_COUNT] = '{
        21'd818, 21'd866, 21'd918, 21'd972, 21'd1030, 21'd1091,
        21'd1156, 21'd1225, 21'd1298, 21'd1375, 21'd1457, 21'd1543,
        21'd1635, 21'd1732, 21'd1835, 21'd1945, 21'd2060, 21'd2183,
        21'd2312, 21'd2450, 21'd2596, 21'd2750, 21'd2914, 21'd3087,
        21'd3270, 21'd3465, 21'd3671, 21'd3889, 21'd4120, 21'd4365,
        21'd4625, 21'd4900, 21'd5191, 21'd5500, 21'd5827, 21'd6174,
        21'd6541, 21'd6930, 21'd7342, 21'd7778, 21'd8241, 21'd8731,
        21'd9250, 21'd9800, 21'd10383, 21'd11000, 21'd11654, 21'd12347,
        21'd13081, 21'd13859, 21'd14683, 21'd15556, 21'd16481, 21'd17461,
        21'd18500, 21'd19600, 21'd20765, 21'd22000, 21'd23308, 21'd24694,
        21'd26163, 21'd27718, 21'd29366, 21'd31113, 21'd32963, 21'd34923,
        21'd36999, 21'd39200, 21'd41530, 21'd44000, 21'd46616, 21'd49388,
        21'd52325, 21'd55437, 21'd58733, 21'd62225, 21'd65926, 21'd69846,
        21'd73999, 21'd78399, 21'd83061, 21'd88000, 21'd93233, 21'd98777,
        21'd104650, 21'd110873, 21'd117466, 21'd124451, 21'd131851, 21'd139691,
        21'd147998, 21'd156798, 21'd166122, 21'd176000, 21'd186466, 21'd197553,
        21'd209300, 21'd221746, 21'd234932, 21'd248902, 21'd263702, 21'd279383,
        21'd295996, 21'd313596, 21'd332244, 21'd352000, 21'd372931, 21'd395107,
        21'd418601, 21'd443492, 21'd469864, 21'd497803, 21'd527404, 21'd558765,
        21'd591991, 21'd627193, 21'd664488, 21'd704000, 21'd745862, 21'd790213,
        21'd837202, 21'd886984, 21'd939727, 21'd995606, 21'd1054808, 21'd1117530,
        21'd1183982, 21'd1254385
    };

    // number of register writes a request kind produces
    function automatic logic [2:0] write_count(input kind_t kind);
        logic [2:0] n;
        begin
            unique case (kind)
                K_SQ_ON:    n = 3'd4;
                K_TRI_ON:   n = 3'd3;
                K_NOISE_ON: n = 3'd3;
                K_RESET:    n = 3'd7;
                default:    n = 3'd1;
            endcase
            return n;
        end
    endfunction

endpackage

// ===== rtl/note_event_to_apu_register_writes.sv =====
`timescale 1ns / 1ps
// Path: a request is registered in the front, queued, loaded by the back end and its writes
//   registered on m_*; a custom-clock square or triangle note-on first waits on the divider.
// Throughput: one register write per cycle from the back end while m_ready allows; a request
//   occupies it until its writes (1 to 7) are out; the front takes one request per cycle while
//   the queue has room, but waits on the divider (1 bit per cycle) for a custom-clock timer.
// Reset: synchronous, active low; clock register to 1789773 Hz, enable mask to 0x0F.
// ============================================================================
// note_event_to_apu_register_writes: note events to sound chip writes
// Front end classifies requests and resolves note timers, a short queue
// decouples it from the back end, which sequences the register writes.
// ============================================================================
module note_event_to_apu_register_writes #(
    parameter int FREQ_FRACTION_BITS = nta_pkg::FREQ_FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH        = nta_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_opcode,
    input  logic [7:0]                  s_channel,
    input  logic [7:0]                  s_note,
    input  logic [7:0]                  s_velocity,
    input  logic [7:0]                  s_enable_bits,
    input  logic [15:0]                 s_raw_address,
    input  logic [7:0]                  s_raw_data,
    // register write channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [15:0]                 m_write_address,
    output logic [7:0]                  m_write_data,
    output logic                        m_last_write,
    // CPU clock register
    input  logic                        cfg_wr_en,
    input  logic [nta_pkg::CLK_W-1:0]   cfg_wr_data
);
    import nta_pkg::*;

    // front -> queue
    logic   fq_valid;
    logic   fq_ready;
    entry_t fq_entry;
    // queue -> back
    logic   qb_valid;
    logic   qb_ready;
    entry_t qb_entry;

    // Front: decodes opcode/channel, drops requests that make no writes,
    // looks up the timer ROM or runs the divider for custom clocks.
    nta_front #(
        .FREQ_FRACTION_BITS (FREQ_FRACTION_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_channel     (s_channel),
        .s_note        (s_note),
        .s_velocity    (s_velocity),
        .s_enable_bits (s_enable_bits),
        .s_raw_address (s_raw_address),
        .s_raw_data    (s_raw_data),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_valid       (fq_valid),
        .q_entry       (fq_entry),
        .q_ready       (fq_ready)
    );

    // Queue lets a long reset sequence drain while new requests come in.
    nta_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_entry (fq_entry),
        .push_ready (fq_ready),
        .pop_valid  (qb_valid),
        .pop_entry  (qb_entry),
        .pop_ready  (qb_ready)
    );

    // Back: one write per cycle into a registered output while m_ready allows; the next request
    // is loaded on the cycle the previous one's last write goes out.
    nta_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_valid       (qb_valid),
        .pop_entry       (qb_entry),
        .pop_ready       (qb_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_address (m_write_address),
        .m_write_data    (m_write_data),
        .m_last_write    (m_last_write)
    );

endmodule

// ===== rtl/nta_timer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nta_timer: note timer at a non-standard CPU clock
// Computes floor((2*clk*2^F - 16f) / (32f)) clamped to 0..2047 with a
// restoring divider that retires one quotient bit per cycle.
// ============================================================================
module nta_timer #(
    parameter int FREQ_FRACTION_BITS = nta_pkg::FREQ_FRACTION_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [nta_pkg::CLK_W-1:0]   clock_hz,
    input  nta_pkg::tmr_req_t           req,
    output nta_pkg::tmr_rsp_t           rsp
);
    import nta_pkg::*;

    localparam int FW = FREQ_FRACTION_BITS + 14;  // fixed-point frequency
    localparam int RW = FREQ_FRACTION_BITS + 30;  // holds 32f << 11

    localparam logic [1:0] TS_IDLE  = 2'd0;
    localparam logic [1:0] TS_PREP  = 2'd1;
    localparam logic [1:0] TS_CHECK = 2'd2;
    localparam logic [1:0] TS_ITER  = 2'd3;

    typedef logic [FW-1:0] freq_rom_t [NOTE_COUNT];

    // frequency in fixed point, rounded half up
    function automatic freq_rom_t build_freq_rom();
        freq_rom_t   rom;
        logic [63:0] v;
        begin
            for (int i = 0; i < NOTE_COUNT; i++) begin
                v = ((64'(FREQ_CENTI[i]) << FREQ_FRACTION_BITS) + 64'd50) / 64'd100;
                if (v == 64'd0) begin
                    v = 64'd1;
                end
                rom[i] = FW'(v);
            end
            return rom;
        end
    endfunction

    localparam freq_rom_t FREQ_ROM = build_freq_rom();

    logic [1:0]          state_reg, state_next;
    logic                done_reg, done_next;
    logic [FW-1:0]       f_reg, f_next;
    logic [RW-1:0]       rem_reg, rem_next;
    logic [RW-1:0]       dsh_reg, dsh_next;
    logic [TIMER_W-1:0]  quo_reg, quo_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [TIMER_W-1:0]  result_reg, result_next;

    logic [RW-1:0]       num;
    logic [RW-1:0]       f16;
    logic                take;

    always_comb begin
        state_next  = state_reg;
        done_next   = 1'b0;
        f_next      = f_reg;
        rem_next    = rem_reg;
        dsh_next    = dsh_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        num         = RW'(clock_hz) << (FREQ_FRACTION_BITS + 1);
        f16         = RW'(f_reg) << 4;
        take        = (rem_reg >= dsh_reg);

        unique case (state_reg)
            TS_IDLE: begin
                if (req.start) begin
                    f_next     = FREQ_ROM[req.note_idx];
                    state_next = TS_PREP;
                end
            end
            TS_PREP: begin
                if (num < f16) begin
                    // rounded value below zero
                    result_next = '0;
                    done_next   = 1'b1;
                    state_next  = TS_IDLE;
                end else begin
                    rem_next   = num - f16;
                    dsh_next   = RW'(f_reg) << (5 + TIMER_W);
                    state_next = TS_CHECK;
                end
            end
            TS_CHECK: begin
                if (take) begin
                    // quotient would need a twelfth bit: saturate
                    result_next = TIMER_MAX;
                    done_next   = 1'b1;
                    state_next  = TS_IDLE;
                end else begin
                    dsh_next   = dsh_reg >> 1;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = TS_ITER;
                end
            end
            TS_ITER: begin
                if (take) begin
                    rem_next = rem_reg - dsh_reg;
                end
                quo_next = {quo_reg[TIMER_W-2:0], take};
                dsh_next = dsh_reg >> 1;
                if (cnt_reg == 4'(TIMER_W - 1)) begin
                    result_next = quo_next;
                    done_next   = 1'b1;
                    state_next  = TS_IDLE;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        f_reg      <= f_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.timer = result_reg;

endmodule

// ===== rtl/nta_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nta_front: request intake and classification
// Holds the clock register, decodes each request into a write kind, looks up
// or computes the note timer and hands the result to the queue.
// ============================================================================
module nta_front #(
    parameter int FREQ_FRACTION_BITS = nta_pkg::FREQ_FRACTION_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_opcode,
    input  logic [7:0]                  s_channel,
    input  logic [7:0]                  s_note,
    input  logic [7:0]                  s_velocity,
    input  logic [7:0]                  s_enable_bits,
    input  logic [15:0]                 s_raw_address,
    input  logic [7:0]                  s_raw_data,
    input  logic                        cfg_wr_en,
    input  logic [nta_pkg::CLK_W-1:0]   cfg_wr_data,
    output logic                        q_valid,
    output nta_pkg::entry_t             q_entry,
    input  logic                        q_ready
);
    import nta_pkg::*;

    logic [CLK_W-1:0]      clk_hz_reg;
    logic                  pend_valid_reg;
    logic                  pend_wait_reg;
    entry_t                pend_reg;

    entry_t                entry_c;
    logic                  has_writes;
    logic                  needs_div;
    logic                  custom_clk;
    logic                  accept;
    logic                  push_ok;
    logic [NOTE_IDX_W-1:0] note_idx;
    tmr_req_t              tmr_req;
    tmr_rsp_t              tmr_rsp;

    assign custom_clk = (clk_hz_reg != '0) && (clk_hz_reg != STD_CLOCK);
    assign note_idx   = s_note[7] ? {NOTE_IDX_W{1'b1}} : s_note[NOTE_IDX_W-1:0];

    always_comb begin
        entry_c        = '0;
        entry_c.sq_sel = s_channel[0];
        entry_c.vol    = s_velocity[6:3];
        entry_c.timer  = TIMER_ROM[note_idx];
        has_writes     = 1'b1;
        needs_div      = 1'b0;
        unique case (s_opcode)
            OP_NOTE_ON: begin
                entry_c.data = {4'h0, s_note[3:0]};
                if (s_channel <= 8'd1) begin
                    entry_c.kind = K_SQ_ON;
                    needs_div    = custom_clk;
                end else if (s_channel == 8'd2) begin
                    entry_c.kind = K_TRI_ON;
                    needs_div    = custom_clk;
                end else if (s_channel == 8'd3) begin
                    entry_c.kind = K_NOISE_ON;
                end else begin
                    has_writes = 1'b0;
                end
            end
            OP_NOTE_OFF: begin
                if (s_channel <= 8'd1) begin
                    entry_c.kind = K_SQ_OFF;
                end else if (s_channel == 8'd2) begin
                    entry_c.kind = K_TRI_OFF;
                end else if (s_channel == 8'd3) begin
                    entry_c.kind = K_NOISE_OFF;
                end else begin
                    has_writes = 1'b0;
                end
            end
            OP_SET_MASK: begin
                entry_c.kind = K_MASK;
                entry_c.data = {3'b000, s_enable_bits[4:0]};
            end
            OP_RAW: begin
                entry_c.kind = K_RAW;
                entry_c.addr = s_raw_address;
                entry_c.data = s_raw_data;
            end
            OP_RESET: begin
                entry_c.kind = K_RESET;
            end
            default: begin
                has_writes = 1'b0;
            end
        endcase
    end

    assign push_ok = pend_valid_reg && !pend_wait_reg && q_ready;
    assign s_ready = !pend_valid_reg || push_ok;
    assign accept  = s_valid && s_ready;

    assign tmr_req.start    = accept && has_writes && needs_div;
    assign tmr_req.note_idx = note_idx;

    nta_timer #(
        .FREQ_FRACTION_BITS (FREQ_FRACTION_BITS)
    ) u_timer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clock_hz (clk_hz_reg),
        .req      (tmr_req),
        .rsp      (tmr_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_hz_reg     <= STD_CLOCK;
            pend_valid_reg <= 1'b0;
            pend_wait_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                clk_hz_reg <= cfg_wr_data;
            end
            if (accept) begin
                pend_valid_reg <= has_writes;
                pend_wait_reg  <= has_writes && needs_div;
            end else if (push_ok) begin
                pend_valid_reg <= 1'b0;
            end else if (tmr_rsp.done) begin
                pend_wait_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg <= entry_c;
        end else if (tmr_rsp.done) begin
            pend_reg.timer <= tmr_rsp.timer;
        end
    end

    assign q_valid = pend_valid_reg && !pend_wait_reg;
    assign q_entry = pend_reg;

endmodule

// ===== rtl/nta_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nta_queue: request queue between front and back end
// Small circular buffer of classified requests.
// ============================================================================
module nta_queue #(
    parameter int QUEUE_DEPTH = nta_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    input  nta_pkg::entry_t  push_entry,
    output logic             push_ready,
    output logic             pop_valid,
    output nta_pkg::entry_t  pop_entry,
    input  logic             pop_ready
);
    import nta_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_entry  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/nta_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nta_back: register write sequencer
// Expands one classified request into its run of register writes, one per
// cycle while the output is not stalled, into the output register. Owns the channel enable mask.
// ============================================================================
module nta_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             pop_valid,
    input  nta_pkg::entry_t  pop_entry,
    output logic             pop_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [15:0]      m_write_address,
    output logic [7:0]       m_write_data,
    output logic             m_last_write
);
    import nta_pkg::*;

    entry_t        cur_reg;
    logic          cur_valid_reg;
    logic [2:0]    step_reg;
    logic [4:0]    enable_mask_reg;
    logic          m_valid_reg;
    logic [15:0]   m_addr_reg;
    logic [7:0]    m_data_reg;
    logic          m_last_reg;

    logic          out_free;
    logic          emit;
    logic          is_last;
    logic [15:0]   wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    timer_hi;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = cur_valid_reg && out_free;
    assign is_last   = (step_reg == 3'(write_count(cur_reg.kind) - 3'd1));
    assign pop_ready = !cur_valid_reg || (emit && is_last);
    assign timer_hi  = {5'b11111, cur_reg.timer[TIMER_W-1:8]};

    always_comb begin
        wr_addr = '0;
        wr_data = '0;
        unique case (cur_reg.kind)
            K_SQ_ON: begin
                wr_addr = 16'h4000 | {13'd0, cur_reg.sq_sel, step_reg[1:0]};
                unique case (step_reg[1:0])
                    2'd0: wr_data = {4'hB, cur_reg.vol};
                    2'd1: wr_data = 8'h08;
                    2'd2: wr_data = cur_reg.timer[7:0];
                    2'd3: wr_data = timer_hi;
                endcase
            end
            K_TRI_ON: begin
                unique case (step_reg)
                    3'd0: begin
                        wr_addr = 16'h4008;
                        wr_data = 8'hFF;
                    end
                    3'd1: begin
                        wr_addr = 16'h400A;
                        wr_data = cur_reg.timer[7:0];
                    end
                    default: begin
                        wr_addr = 16'h400B;
                        wr_data = timer_hi;
                    end
                endcase
            end
            K_NOISE_ON: begin
                unique case (step_reg)
                    3'd0: begin
                        wr_addr = 16'h400C;
                        wr_data = {4'h3, cur_reg.vol};
                    end
                    3'd1: begin
                        wr_addr = 16'h400E;
                        wr_data = {4'h0, cur_reg.data[3:0]};
                    end
                    default: begin
                        wr_addr = 16'h400F;
                        wr_data = 8'hF8;
                    end
                endcase
            end
            K_SQ_OFF: begin
                wr_addr = 16'h4000 | {13'd0, cur_reg.sq_sel, 2'b00};
                wr_data = 8'h30;
            end
            K_TRI_OFF: begin
                wr_addr = 16'h4008;
                wr_data = 8'h80;
            end
            K_NOISE_OFF: begin
                wr_addr = 16'h400C;
                wr_data = 8'h30;
            end
            K_MASK: begin
                wr_addr = 16'h4015;
                wr_data = {3'b000, enable_mask_reg};
            end
            K_RAW: begin
                wr_addr = cur_reg.addr;
                wr_data = cur_reg.data;
            end
            K_RESET: begin
                // silence sweeps, mute all channels, restore enables
                unique case (step_reg)
                    3'd0: begin wr_addr = 16'h4001; wr_data = 8'h08; end
                    3'd1: begin wr_addr = 16'h4005; wr_data = 8'h08; end
                    3'd2: begin wr_addr = 16'h4000; wr_data = 8'h30; end
                    3'd3: begin wr_addr = 16'h4004; wr_data = 8'h30; end
                    3'd4: begin wr_addr = 16'h4008; wr_data = 8'h80; end
                    3'd5: begin wr_addr = 16'h400C; wr_data = 8'h30; end
                    default: begin wr_addr = 16'h4015; wr_data = ENABLE_RESET; end
                endcase
            end
            default: begin
                wr_addr = '0;
                wr_data = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg   <= 1'b0;
            step_reg        <= '0;
            enable_mask_reg <= ENABLE_RESET[4:0];
            m_valid_reg     <= 1'b0;
        end else begin
            if (out_free) begin
                m_valid_reg <= emit;
            end
            if (pop_valid && pop_ready) begin
                cur_valid_reg <= 1'b1;
                step_reg      <= '0;
                if (pop_entry.kind == K_MASK) begin
                    enable_mask_reg <= pop_entry.data[4:0];
                end else if (pop_entry.kind == K_RESET) begin
                    enable_mask_reg <= ENABLE_RESET[4:0];
                end
            end else if (emit) begin
                if (is_last) begin
                    cur_valid_reg <= 1'b0;
                end else begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            cur_reg <= pop_entry;
        end
        if (emit) begin
            m_addr_reg <= wr_addr;
            m_data_reg <= wr_data;
            m_last_reg <= is_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_write_address = m_addr_reg;
    assign m_write_data    = m_data_reg;
    assign m_last_write    = m_last_reg;

endmodule

// ===== rtl/nta_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nta_checker: port-level checks for the note event translator
// Watches the top-level ports only; attached by bind.
// ============================================================================
module nta_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [15:0]                 m_write_address,
    input logic [7:0]                  m_write_data,
    input logic                        m_last_write
);

    // stalled write holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_write_address)
                                && $stable(m_write_data) && $stable(m_last_write))
        else $error("stalled write changed");

    // no write right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("write valid after reset");

    // enable register write always ends a run
    a_mask_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_address == 16'h4015 |-> m_last_write)
        else $error("enable write not last in run");

    // mid-run writes only hit channel registers
    a_mid_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_write |-> m_write_address[15:4] == 12'h400
                                     && m_write_address != 16'h400F)
        else $error("mid-run write outside channel registers");

endmodule

bind note_event_to_apu_register_writes nta_checker u_nta_checker (.*);
